### src/qplp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qplp_pkg
// Shared types and constants for the QUIC first-packet length parser.
// ----------------------------------------------------------------------------
package qplp_pkg;

    localparam int PHASE_W = 4;
    localparam int KIND_W  = 3;
    localparam int LEN_W   = 64;
    localparam int VAR_W   = 62;
    localparam int SCID_W  = 5;

    // Parse phases
    localparam logic [PHASE_W-1:0] PH_IDLE      = 4'd0;
    localparam logic [PHASE_W-1:0] PH_VERSION   = 4'd1;
    localparam logic [PHASE_W-1:0] PH_DCID_LEN  = 4'd2;
    localparam logic [PHASE_W-1:0] PH_DCID      = 4'd3;
    localparam logic [PHASE_W-1:0] PH_SCID_LEN  = 4'd4;
    localparam logic [PHASE_W-1:0] PH_SCID      = 4'd5;
    localparam logic [PHASE_W-1:0] PH_TOKEN_LEN = 4'd6;
    localparam logic [PHASE_W-1:0] PH_TOKEN     = 4'd7;
    localparam logic [PHASE_W-1:0] PH_LENGTH    = 4'd8;
    localparam logic [PHASE_W-1:0] PH_ODCID_LEN = 4'd9;
    localparam logic [PHASE_W-1:0] PH_ODCID     = 4'd10;
    localparam logic [PHASE_W-1:0] PH_SHORT     = 4'd11;
    localparam logic [PHASE_W-1:0] PH_DRAIN     = 4'd12;

    // Header kinds
    localparam logic [KIND_W-1:0] KIND_INITIAL   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ZERO_RTT  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_HANDSHAKE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RETRY     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SHORT     = 3'd4;

    // Result status
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_SHORT = 1'b1;

    localparam logic [SCID_W-1:0] SCID_LEN_RESET = 5'd8;
    localparam logic [VAR_W-1:0]  VERSION_BYTES  = 62'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_word_t;

endpackage

### src/qplp_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qplp_in_stage
// Input register: holds one byte word ahead of the parser.
// ----------------------------------------------------------------------------
module qplp_in_stage
    import qplp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  byte_word_t in_word,
    output logic       down_valid,
    input  logic       down_ready,
    output byte_word_t down_word
);

    logic       valid_reg;
    byte_word_t word_reg;

    assign in_ready   = !valid_reg || down_ready;
    assign down_valid = valid_reg;
    assign down_word  = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= in_word;
        end
    end

endmodule

### src/qplp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qplp_core
// Header parse, one byte per cycle unless a result stalls; result register.
// ----------------------------------------------------------------------------
module qplp_core
    import qplp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  byte_word_t        in_word,
    input  logic [SCID_W-1:0] scid_len,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              status,
    output logic [KIND_W-1:0] header_kind,
    output logic [LEN_W-1:0]  first_pkt_len
);

    // offset_reg counts bytes including the one being parsed
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [LEN_W-1:0]   offset_reg, offset_next;
    logic [VAR_W-1:0]   skip_reg, skip_next;
    logic [VAR_W-1:0]   acc_reg, acc_next;
    logic [2:0]         vleft_reg, vleft_next;
    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic               sent_reg, sent_next;

    logic               out_valid_reg;
    logic               status_reg, status_next;
    logic [KIND_W-1:0]  kind_out_reg;
    logic [LEN_W-1:0]   len_reg, len_next;

    logic [7:0]         b;
    logic               last;
    logic [VAR_W-1:0]   vacc;
    logic [2:0]         vleft_v;
    logic               vdone;
    logic [VAR_W-1:0]   skip_dec;
    logic               skip_hit;
    logic               done;
    logic               fire;
    logic [VAR_W-1:0]   payload;
    logic [LEN_W-1:0]   short_min;
    logic               accept;

    function automatic logic [PHASE_W-1:0] tail_phase(input logic [KIND_W-1:0] k);
        logic [PHASE_W-1:0] p;
        if (k == KIND_INITIAL)
            p = PH_TOKEN_LEN;
        else if (k == KIND_RETRY)
            p = PH_ODCID_LEN;
        else
            p = PH_LENGTH;
        return p;
    endfunction

    assign b         = in_word.data_byte;
    assign last      = in_word.last_byte;
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign skip_dec  = skip_reg - 62'd1;
    assign skip_hit  = (skip_reg == 62'd1);
    assign short_min = {{(LEN_W-SCID_W-1){1'b0}}, {1'b0, scid_len} + 6'd1};

    // varint reader: prefix byte sets the count, later bytes shift in
    always_comb
    begin
        if (vleft_reg == 3'd0)
        begin
            unique case (b[7:6])
                2'd0: vleft_v = 3'd0;
                2'd1: vleft_v = 3'd1;
                2'd2: vleft_v = 3'd3;
                2'd3: vleft_v = 3'd7;
                default: vleft_v = 3'd0;
            endcase
            vacc = {{(VAR_W-6){1'b0}}, b[5:0]};
        end
        else
        begin
            vleft_v = vleft_reg - 3'd1;
            vacc    = {acc_reg[VAR_W-9:0], b};
        end
        vdone = (vleft_v == 3'd0);
    end

    always_comb
    begin
        phase_next  = phase_reg;
        skip_next   = skip_reg;
        acc_next    = acc_reg;
        vleft_next  = vleft_reg;
        kind_next   = kind_reg;
        sent_next   = sent_reg;
        done        = 1'b0;
        payload     = '0;
        fire        = 1'b0;
        status_next = STATUS_OK;
        len_next    = '0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (b[7])
                begin
                    kind_next  = {1'b0, b[5:4]};
                    skip_next  = VERSION_BYTES;
                    phase_next = PH_VERSION;
                end
                else
                begin
                    kind_next  = KIND_SHORT;
                    phase_next = PH_SHORT;
                end
            end
            PH_VERSION, PH_DCID, PH_SCID, PH_TOKEN, PH_ODCID:
            begin
                skip_next = skip_dec;
                if (skip_hit)
                begin
                    priority if (phase_reg == PH_VERSION)
                        phase_next = PH_DCID_LEN;
                    else if (phase_reg == PH_DCID)
                        phase_next = PH_SCID_LEN;
                    else if (phase_reg == PH_SCID)
                    begin
                        vleft_next = 3'd0;
                        phase_next = tail_phase(kind_reg);
                    end
                    else if (phase_reg == PH_TOKEN)
                    begin
                        vleft_next = 3'd0;
                        phase_next = PH_LENGTH;
                    end
                    else
                        done = 1'b1;
                end
            end
            PH_DCID_LEN:
            begin
                skip_next  = {{(VAR_W-8){1'b0}}, b};
                phase_next = (b == 8'd0) ? PH_SCID_LEN : PH_DCID;
            end
            PH_SCID_LEN:
            begin
                skip_next = {{(VAR_W-8){1'b0}}, b};
                if (b == 8'd0)
                begin
                    vleft_next = 3'd0;
                    phase_next = tail_phase(kind_reg);
                end
                else
                    phase_next = PH_SCID;
            end
            PH_ODCID_LEN:
            begin
                skip_next = {{(VAR_W-8){1'b0}}, b};
                if (b == 8'd0)
                    done = 1'b1;
                else
                    phase_next = PH_ODCID;
            end
            PH_TOKEN_LEN:
            begin
                acc_next   = vacc;
                vleft_next = vleft_v;
                if (vdone)
                begin
                    skip_next  = vacc;
                    vleft_next = 3'd0;
                    phase_next = (vacc == '0) ? PH_LENGTH : PH_TOKEN;
                end
            end
            PH_LENGTH:
            begin
                acc_next   = vacc;
                vleft_next = vleft_v;
                if (vdone)
                begin
                    payload = vacc;
                    done    = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        if (done)
        begin
            fire        = 1'b1;
            status_next = STATUS_OK;
            len_next    = offset_reg + {2'b00, payload};
            sent_next   = 1'b1;
            phase_next  = PH_DRAIN;
        end
        else if (last && !sent_reg)
        begin
            fire      = 1'b1;
            sent_next = 1'b1;
            if (phase_next == PH_SHORT && offset_reg >= short_min)
            begin
                status_next = STATUS_OK;
                len_next    = offset_reg;
            end
            else
            begin
                status_next = STATUS_SHORT;
                len_next    = '0;
            end
        end

        if (last)
        begin
            phase_next  = PH_IDLE;
            offset_next = {{(LEN_W-1){1'b0}}, 1'b1};
            skip_next   = '0;
            acc_next    = '0;
            vleft_next  = 3'd0;
            sent_next   = 1'b0;
        end
        else
        begin
            offset_next = offset_reg + 64'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            offset_reg    <= {{(LEN_W-1){1'b0}}, 1'b1};
            skip_reg      <= '0;
            acc_reg       <= '0;
            vleft_reg     <= 3'd0;
            kind_reg      <= KIND_INITIAL;
            sent_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg  <= phase_next;
                offset_reg <= offset_next;
                skip_reg   <= skip_next;
                acc_reg    <= acc_next;
                vleft_reg  <= vleft_next;
                kind_reg   <= last ? KIND_INITIAL : kind_next;
                sent_reg   <= sent_next;
            end
            if (in_ready)
            begin
                out_valid_reg <= accept && fire;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && fire)
        begin
            status_reg   <= status_next;
            kind_out_reg <= kind_next;
            len_reg      <= len_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign header_kind   = kind_out_reg;
    assign first_pkt_len = len_reg;

endmodule

### src/quic_packet_length_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quic_packet_length_parser_top
// Finds the header kind and first-packet length of a QUIC datagram.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------
//  in      | in_valid / in_ready  | data_byte[7:0], last_byte
//  out     | out_valid / out_ready| status, header_kind[2:0], first_pkt_len[63:0]
//  cfg     | cfg_valid / cfg_ready| short_conn_id_len[4:0]
//
//  One byte word per cycle sustained while no result stalls; the per-byte
//  parse step sits between the input register and the result register, so
//  a result is registered when the parser accepts the completing byte.
//  Reset: parser idle, short_conn_id_len = 8. cfg_ready is always high.
//  A stalled result holds in the result register; the input register
//  takes at most one more word before in_ready drops.
// ----------------------------------------------------------------------------
module quic_packet_length_parser_top
    import qplp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              status,
    output logic [KIND_W-1:0] header_kind,
    output logic [LEN_W-1:0]  first_pkt_len,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [SCID_W-1:0] short_conn_id_len
);

    logic [SCID_W-1:0] scid_len_reg;
    byte_word_t        in_word;
    byte_word_t        core_word;
    logic              core_valid;
    logic              core_ready;

    assign cfg_ready         = 1'b1;
    assign in_word.data_byte = data_byte;
    assign in_word.last_byte = last_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scid_len_reg <= SCID_LEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            scid_len_reg <= short_conn_id_len;
        end
    end

    qplp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_word    (in_word),
        .down_valid (core_valid),
        .down_ready (core_ready),
        .down_word  (core_word)
    );

    qplp_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (core_valid),
        .in_ready      (core_ready),
        .in_word       (core_word),
        .scid_len      (scid_len_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .header_kind   (header_kind),
        .first_pkt_len (first_pkt_len)
    );

    // failed parse never carries a length
    a_short_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STATUS_SHORT) |-> (first_pkt_len == '0))
        else $error("insufficient-data result with nonzero length");

    // input side only backs up behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without a pending result");

    // a good short-header result covers at least the first byte
    a_short_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STATUS_OK && header_kind == KIND_SHORT)
            |-> (first_pkt_len != '0))
        else $error("short-header result with zero length");

    // header kind is one of the five reported codes
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (header_kind[2] == 1'b0 || header_kind == KIND_SHORT))
        else $error("bad header kind on result");

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the QUIC first-packet length parser. Whole
// datagrams are fed one byte word at a time, and an in-bench parser model
// predicts untyped results. The bench starts with a short directed table, then
// sends random long-header, short-header, truncated and noise datagrams under
// several connection ID length settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    import qplp_pkg::*;

    typedef struct packed {
        logic              status;
        logic [KIND_W-1:0] kind;
        logic [LEN_W-1:0]  len;
    } len_result_t;

    typedef struct packed {
        logic [7:0]        data;
        logic              last;
        logic              typed;
        logic              st;
        logic [KIND_W-1:0] kind;
        logic [LEN_W-1:0]  len;
    } dir_row_t;

    localparam int N_DIR = 26;

    // single-byte short datagram, minimal retry plus an ignored trailing
    // byte, handshake with the largest 8-byte length, one-byte initial
    localparam dir_row_t DIR_ROWS [0:N_DIR-1] = '{
        '{8'h00, 1'b1, 1'b1, STATUS_SHORT, KIND_SHORT,     64'd0},
        '{8'hB0, 1'b0, 1'b0, STATUS_OK,    KIND_INITIAL,   64'd0},
        '{8'hFF, 1'b0, 1'b0, STATUS_OK,    KIND_INITIAL,   64'd0},
        '{8'h00, 1'b0, 1'b0, STATUS_OK,    KIND_INITIAL,   64'd0},
        '{8'h00, 1'b0, 1'b0, STATUS_OK,    KIND_INITIAL,   64'd0},
        '{8'h01, 1'b0, 1'b0, STATUS_OK,    KIND_INITIAL,   64'd0},
        '{8'h00, 1'b0, 1'b0, STATUS_OK,    KIND_INITIAL,   64'd0},
        '{8'h00, 1'b0, 1'b0, STATUS_OK,    KIND_INITIAL,   64'd0},
        '{8'h00, 1'b0, 1'b1, STATUS_OK,    KIND_RETRY,     64'd8},
        '{8'h55, 1'b1, 1'b0, STATUS_OK,    KIND_INITIAL,   64'd0},
        '{8'hE0, 1'b0, 1'b0, STATUS_OK,    KIND_INITIAL,   64'd0},
        '{8'h00, 1'b0, 1'b0, STATUS_OK,    KIND_INITIAL,   64'd0},
        '{8'h00, 1'b0, 1'b0, STATUS_OK,    KIND_INITIAL,   64'd0},
        '{8'h00, 1'b0, 1'b0, STATUS_OK,    KIND_INITIAL,   64'd0},
        '{8'h01, 1'b0, 1'b0, STATUS_OK,    KIND_INITIAL,   64'd0},
        '{8'h00, 1'b0, 1'b0, STATUS_OK,    KIND_INITIAL,   64'd0},
        '{8'h00, 1'b0, 1'b0, STATUS_OK,    KIND_INITIAL,   64'd0},
        '{8'hFF, 1'b0, 1'b0, STATUS_OK,    KIND_INITIAL,   64'd0},
        '{8'hFF, 1'b0, 1'b0, STATUS_OK,    KIND_INITIAL,   64'd0},
        '{8'hFF, 1'b0, 1'b0, STATUS_OK,    KIND_INITIAL,   64'd0},
        '{8'hFF, 1'b0, 1'b0, STATUS_OK,    KIND_INITIAL,   64'd0},
        '{8'hFF, 1'b0, 1'b0, STATUS_OK,    KIND_INITIAL,   64'd0},
        '{8'hFF, 1'b0, 1'b0, STATUS_OK,    KIND_INITIAL,   64'd0},
        '{8'hFF, 1'b0, 1'b0, STATUS_OK,    KIND_INITIAL,   64'd0},
        '{8'hFF, 1'b1, 1'b1, STATUS_OK,    KIND_HANDSHAKE, 64'h4000_0000_0000_000E},
        '{8'hC0, 1'b1, 1'b1, STATUS_SHORT, KIND_INITIAL,   64'd0}
    };

    localparam int N_PHASES     = 6;
    localparam int PHASE_BYTES  = 105;
    localparam int IDLE_PCT     = 31;
    localparam int SETTLE_CYC   = 8;
    localparam int MAX_REPORTS  = 10;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [7:0]        data_byte = '0;
    logic              last_byte = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              res_status;
    logic [KIND_W-1:0] res_kind;
    logic [LEN_W-1:0]  res_len;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [SCID_W-1:0] cfg_len = '0;

    bit                idle_en = 1'b1;
    int                fail_cnt = 0;
    len_result_t       pending_lens[$];
    logic [7:0]        dgram[$];

    // parser model state
    logic [PHASE_W-1:0] p_phase;
    logic [LEN_W-1:0]   p_offset;
    logic [VAR_W-1:0]   p_skip;
    logic [VAR_W-1:0]   p_acc;
    logic [2:0]         p_vleft;
    logic [KIND_W-1:0]  p_kind;
    logic               p_sent;
    logic [SCID_W-1:0]  p_cid_len;

    quic_packet_length_parser_top u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .data_byte         (data_byte),
        .last_byte         (last_byte),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .status            (res_status),
        .header_kind       (res_kind),
        .first_pkt_len     (res_len),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .short_conn_id_len (cfg_len)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void clear_parse();
        p_phase  = PH_IDLE;
        p_offset = '0;
        p_skip   = '0;
        p_acc    = '0;
        p_vleft  = '0;
        p_kind   = '0;
        p_sent   = 1'b0;
    endfunction

    function automatic void enter_tail();
        p_vleft = '0;
        if (p_kind == KIND_INITIAL)
            p_phase = PH_TOKEN_LEN;
        else if (p_kind == KIND_RETRY)
            p_phase = PH_ODCID_LEN;
        else
            p_phase = PH_LENGTH;
    endfunction

    // returns 1 once the varint is complete
    function automatic bit feed_varint(input logic [7:0] b);
        if (p_vleft == '0)
        begin
            p_vleft = 3'((4'd1 << b[7:6]) - 4'd1);
            p_acc   = VAR_W'(b[5:0]);
        end
        else
        begin
            p_acc   = {p_acc[VAR_W-9:0], b};
            p_vleft = p_vleft - 3'd1;
        end
        return p_vleft == '0;
    endfunction

    task automatic parse_byte(input logic [7:0] b, input logic l,
                              output bit has, output len_result_t r);
        logic             done;
        logic [LEN_W-1:0] payload;
        done     = 1'b0;
        payload  = '0;
        has      = 1'b0;
        r        = '0;
        p_offset = p_offset + 64'd1;
        case (p_phase)
            PH_IDLE:
            begin
                if (b[7])
                begin
                    p_kind  = KIND_W'(b[5:4]);
                    p_skip  = VERSION_BYTES;
                    p_phase = PH_VERSION;
                end
                else
                begin
                    p_kind  = KIND_SHORT;
                    p_phase = PH_SHORT;
                end
            end
            PH_VERSION, PH_DCID, PH_SCID, PH_TOKEN, PH_ODCID:
            begin
                p_skip = p_skip - 1'b1;
                if (p_skip == '0)
                begin
                    case (p_phase)
                        PH_VERSION: p_phase = PH_DCID_LEN;
                        PH_DCID:    p_phase = PH_SCID_LEN;
                        PH_SCID:    enter_tail();
                        PH_TOKEN:
                        begin
                            p_vleft = '0;
                            p_phase = PH_LENGTH;
                        end
                        default:    done = 1'b1;
                    endcase
                end
            end
            PH_DCID_LEN:
            begin
                p_skip  = VAR_W'(b);
                p_phase = (b == 8'd0) ? PH_SCID_LEN : PH_DCID;
            end
            PH_SCID_LEN:
            begin
                p_skip = VAR_W'(b);
                if (b == 8'd0)
                    enter_tail();
                else
                    p_phase = PH_SCID;
            end
            PH_ODCID_LEN:
            begin
                p_skip = VAR_W'(b);
                if (b == 8'd0)
                    done = 1'b1;
                else
                    p_phase = PH_ODCID;
            end
            PH_TOKEN_LEN:
            begin
                if (feed_varint(b))
                begin
                    p_skip  = p_acc;
                    p_vleft = '0;
                    p_phase = (p_acc == '0) ? PH_LENGTH : PH_TOKEN;
                end
            end
            PH_LENGTH:
            begin
                if (feed_varint(b))
                begin
                    payload = LEN_W'(p_acc);
                    done    = 1'b1;
                end
            end
            default: ;
        endcase

        if (done)
        begin
            r       = '{STATUS_OK, p_kind, p_offset + payload};
            has     = 1'b1;
            p_sent  = 1'b1;
            p_phase = PH_DRAIN;
        end
        else if (l && !p_sent)
        begin
            if (p_phase == PH_SHORT && p_offset >= LEN_W'(p_cid_len) + 64'd1)
                r = '{STATUS_OK, p_kind, p_offset};
            else
                r = '{STATUS_SHORT, p_kind, 64'd0};
            has    = 1'b1;
            p_sent = 1'b1;
        end
        if (l)
            clear_parse();
    endtask

    // one byte word on the input channel; a typed result overrides the model's
    task automatic send_word(input logic [7:0] d, input logic l,
                             input bit use_typed, input len_result_t typed_res);
        bit          has;
        len_result_t r;
        if (idle_en)
        begin
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid  <= 1'b1;
        data_byte <= d;
        last_byte <= l;
        do @(posedge clk); while (!in_ready);
        parse_byte(d, l, has, r);
        if (use_typed)
            pending_lens.push_back(typed_res);
        else if (has)
            pending_lens.push_back(r);
    endtask

    // sender holds off until every expected result is out, then lets the
    // pipeline settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_lens.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [SCID_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_len   <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        p_cid_len = v;
    endtask

    task automatic push_varint(input logic [1:0] code, input logic [63:0] v);
        int          nb;
        logic [63:0] enc;
        nb  = 1 << code;
        enc = (v & ((64'd1 << (8 * nb - 2)) - 64'd1)) | (64'(code) << (8 * nb - 2));
        for (int i = nb - 1; i >= 0; i--)
            dgram.push_back(enc[8 * i +: 8]);
    endtask

    task automatic push_random(input int n);
        repeat (n) dgram.push_back(8'($urandom));
    endtask

    task automatic build_datagram();
        int         pick;
        int         n;
        logic [7:0] first;
        dgram.delete();
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            first    = 8'($urandom);
            first[7] = 1'b1;
            dgram.push_back(first);
            push_random(4);
            // dest and source connection IDs; now and then a long one
            repeat (2)
            begin
                n = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255)
                                                 : $urandom_range(0, 20);
                dgram.push_back(8'(n));
                push_random(n);
            end
            if (KIND_W'(first[5:4]) == KIND_RETRY)
            begin
                n = $urandom_range(0, 20);
                dgram.push_back(8'(n));
                push_random(n);
            end
            else
            begin
                if (KIND_W'(first[5:4]) == KIND_INITIAL)
                begin
                    n = $urandom_range(0, 12);
                    push_varint(2'($urandom), 64'(n));
                    push_random(n);
                end
                push_varint(2'($urandom), {$urandom, $urandom});
            end
            push_random($urandom_range(0, 6));
            if ($urandom_range(0, 4) == 0 && dgram.size() > 1)
            begin
                n = $urandom_range(1, dgram.size() - 1);
                while (dgram.size() > n)
                    void'(dgram.pop_back());
            end
        end
        else if (pick < 80)
        begin
            first    = 8'($urandom);
            first[7] = 1'b0;
            dgram.push_back(first);
            push_random($urandom_range(0, int'(p_cid_len) + 5));
        end
        else
        begin
            push_random($urandom_range(1, 12));
        end
    endtask

    always @(posedge clk)
    begin
        out_ready <= idle_en ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
    end

    always @(posedge clk)
    begin : result_check
        len_result_t want;
        len_result_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{res_status, res_kind, res_len};
            if (pending_lens.size() == 0)
            begin
                fail_cnt++;
                if (fail_cnt <= MAX_REPORTS)
                    $display("ERROR: unexpected result status=%0d kind=%0d len=%0h",
                             got.status, got.kind, got.len);
            end
            else
            begin
                want = pending_lens.pop_front();
                if (got != want)
                begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_REPORTS)
                    begin
                        $write("ERROR: result mismatch exp status=%0d kind=%0d len=%0h",
                               want.status, want.kind, want.len);
                        $display(" got status=%0d kind=%0d len=%0h",
                                 got.status, got.kind, got.len);
                    end
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        logic [SCID_W-1:0] cfg_plan [N_PHASES];
        int                phase_bytes;
        len_result_t       typed_res;

        p_cid_len = SCID_LEN_RESET;
        clear_parse();
        cfg_plan = '{5'd0, 5'd31, 5'd20, 5'd1, 5'($urandom), 5'($urandom)};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIR; i++)
        begin
            typed_res = '{DIR_ROWS[i].st, DIR_ROWS[i].kind, DIR_ROWS[i].len};
            send_word(DIR_ROWS[i].data, DIR_ROWS[i].last, DIR_ROWS[i].typed, typed_res);
        end
        wait_drained();

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            write_cfg(cfg_plan[ph]);
            idle_en     = (ph != 1);
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES)
            begin
                build_datagram();
                for (int i = 0; i < dgram.size(); i++)
                    send_word(dgram[i], i == dgram.size() - 1, 1'b0, '0);
                phase_bytes += dgram.size();
                if ($urandom_range(0, 9) == 0)
                    wait_drained();
            end
            wait_drained();
        end

        idle_en = 1'b1;
        if (pending_lens.size() != 0)
            fail_cnt++;
        if (fail_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### files.f
src/qplp_pkg.sv
src/qplp_in_stage.sv
src/qplp_core.sv
src/quic_packet_length_parser_top.sv
verif/tb_top.sv
